@@ rtl/core/qlhp_pkg.sv @@
// ----------------------------------------------------------------------------
// qlhp_pkg
// Shared types and codes for the QUIC long-header parser.
// ----------------------------------------------------------------------------
package qlhp_pkg;

  // Parse phase: which part of the header the next byte belongs to
  typedef enum logic [3:0] {
    PH_FIRST = 4'd0,
    PH_VER   = 4'd1,
    PH_DLEN  = 4'd2,
    PH_DCID  = 4'd3,
    PH_SLEN  = 4'd4,
    PH_SCID  = 4'd5,
    PH_TVAR  = 4'd6,
    PH_TOK   = 4'd7,
    PH_LVAR  = 4'd8,
    PH_PN    = 4'd9,
    PH_IGN   = 4'd10
  } phase_t;

  // Status codes; a truncated packet gives ST_RUNT below MIN_LONG_BYTES bytes, else its phase plus ST_STAGE_OFS
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_RUNT      = 4'd2;
  localparam logic [3:0] ST_STAGE_OFS = 4'd2;

  // Varint length codes, top two bits of the first varint byte
  localparam logic [1:0] VI_LEN1 = 2'd0;
  localparam logic [1:0] VI_LEN2 = 2'd1;
  localparam logic [1:0] VI_LEN4 = 2'd2;
  localparam logic [1:0] VI_LEN8 = 2'd3;

  localparam logic [2:0] MIN_LONG_BYTES = 3'd7;
  localparam logic [7:0] VERSION_BYTES  = 8'd4;

endpackage

@@ rtl/core/quic_long_header_parser.sv @@
// ----------------------------------------------------------------------------
// quic_long_header_parser
// Byte-serial QUIC v1 long-header decoder with one result per packet.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per clock while in_ready is high and gives
// at most one result per packet: ok after the last packet-number byte, short
// header right at the first byte, or a truncation status when the byte marked
// last arrives first. The whole phase update runs between the state
// registers and a single result register, so in_ready stays high unless a
// result is waiting and out_ready is low. A result appears on the outputs in
// the cycle after the byte that completes it is accepted.
module quic_long_header_parser
  import qlhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic        out_form_bit,
  output logic        out_fixed_flag,
  output logic [1:0]  out_long_type,
  output logic [1:0]  out_reserved_field,
  output logic [2:0]  out_pn_length,
  output logic [31:0] out_version_word,
  output logic [7:0]  out_dest_id_length,
  output logic [7:0]  out_src_id_length,
  output logic [7:0]  out_token_size,
  output logic [15:0] out_payload_size,
  output logic [31:0] out_packet_num
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [2:0]  vleft_r, vleft_nxt;
  logic [15:0] vacc_r, vacc_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [7:0]  dlen_r, dlen_nxt;
  logic [7:0]  slen_r, slen_nxt;
  logic [7:0]  tlen_r, tlen_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [31:0] pn_r, pn_nxt;

  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [7:0]  out_flag_r;
  logic [31:0] out_ver_r;
  logic [7:0]  out_dlen_r;
  logic [7:0]  out_slen_r;
  logic [7:0]  out_tlen_r;
  logic [15:0] out_plen_r;
  logic [31:0] out_pn_r;

  logic        in_fire;
  logic        emit;
  logic [3:0]  emit_status;

  // varint byte step, shared by the token and payload length phases
  logic [2:0]  v_left_step;
  logic [15:0] v_acc_step;
  logic        v_done;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    v_left_step = vleft_r;
    if (vleft_r == 3'd0) begin
      v_acc_step = {10'd0, in_data_byte[5:0]};
      unique case (in_data_byte[7:6])
        VI_LEN1: v_left_step = 3'd0;
        VI_LEN2: v_left_step = 3'd1;
        VI_LEN4: v_left_step = 3'd3;
        VI_LEN8: v_left_step = 3'd7;
      endcase
    end else begin
      v_acc_step  = {vacc_r[7:0], in_data_byte};
      v_left_step = vleft_r - 3'd1;
    end
    v_done = (v_left_step == 3'd0);
  end

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    vleft_nxt   = vleft_r;
    vacc_nxt    = vacc_r;
    flag_nxt    = flag_r;
    ver_nxt     = ver_r;
    dlen_nxt    = dlen_r;
    slen_nxt    = slen_r;
    tlen_nxt    = tlen_r;
    plen_nxt    = plen_r;
    pn_nxt      = pn_r;
    emit        = 1'b0;
    emit_status = ST_OK;

    if (phase_r == PH_FIRST) begin
      cnt_nxt = 3'd1;
    end else if (cnt_r < MIN_LONG_BYTES) begin
      cnt_nxt = cnt_r + 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end

    unique case (phase_r)
      PH_FIRST: begin
        flag_nxt  = in_data_byte;
        ver_nxt   = '0;
        dlen_nxt  = '0;
        slen_nxt  = '0;
        tlen_nxt  = '0;
        plen_nxt  = '0;
        pn_nxt    = '0;
        vleft_nxt = '0;
        vacc_nxt  = '0;
        if (!in_data_byte[7]) begin
          emit        = 1'b1;
          emit_status = ST_SHORT;
        end else begin
          skip_nxt  = VERSION_BYTES;
          phase_nxt = PH_VER;
        end
      end
      PH_VER: begin
        ver_nxt  = {ver_r[23:0], in_data_byte};
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) phase_nxt = PH_DLEN;
      end
      PH_DLEN: begin
        dlen_nxt  = in_data_byte;
        skip_nxt  = in_data_byte;
        phase_nxt = (in_data_byte != 8'd0) ? PH_DCID : PH_SLEN;
      end
      PH_DCID: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) phase_nxt = PH_SLEN;
      end
      PH_SLEN: begin
        slen_nxt  = in_data_byte;
        skip_nxt  = in_data_byte;
        phase_nxt = (in_data_byte != 8'd0) ? PH_SCID : PH_TVAR;
      end
      PH_SCID: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) phase_nxt = PH_TVAR;
      end
      PH_TVAR: begin
        vleft_nxt = v_left_step;
        vacc_nxt  = v_acc_step;
        if (v_done) begin
          tlen_nxt  = v_acc_step[7:0];
          skip_nxt  = v_acc_step[7:0];
          phase_nxt = (v_acc_step[7:0] != 8'd0) ? PH_TOK : PH_LVAR;
        end
      end
      PH_TOK: begin
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) phase_nxt = PH_LVAR;
      end
      PH_LVAR: begin
        vleft_nxt = v_left_step;
        vacc_nxt  = v_acc_step;
        if (v_done) begin
          plen_nxt  = v_acc_step;
          skip_nxt  = {6'd0, flag_r[1:0]} + 8'd1;
          phase_nxt = PH_PN;
        end
      end
      PH_PN: begin
        pn_nxt   = {pn_r[23:0], in_data_byte};
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) begin
          emit        = 1'b1;
          emit_status = ST_OK;
        end
      end
      default: begin
      end
    endcase

    // end of packet: finish, drop trailing bytes, or report truncation
    priority if (emit) begin
      phase_nxt = in_last_byte ? PH_FIRST : PH_IGN;
    end else if (in_last_byte) begin
      if (phase_nxt < PH_IGN) begin
        emit        = 1'b1;
        emit_status = (cnt_nxt < MIN_LONG_BYTES) ? ST_RUNT
                    : (4'(phase_nxt) + ST_STAGE_OFS);
      end
      phase_nxt = PH_FIRST;
    end else begin
      // mid-packet byte: keep the phase chosen above
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      cnt_r       <= '0;
      skip_r      <= '0;
      vleft_r     <= '0;
      vacc_r      <= '0;
      flag_r      <= '0;
      ver_r       <= '0;
      dlen_r      <= '0;
      slen_r      <= '0;
      tlen_r      <= '0;
      plen_r      <= '0;
      pn_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        skip_r  <= skip_nxt;
        vleft_r <= vleft_nxt;
        vacc_r  <= vacc_nxt;
        flag_r  <= flag_nxt;
        ver_r   <= ver_nxt;
        dlen_r  <= dlen_nxt;
        slen_r  <= slen_nxt;
        tlen_r  <= tlen_nxt;
        plen_r  <= plen_nxt;
        pn_r    <= pn_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on a completing request, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_status_r <= emit_status;
      out_flag_r   <= flag_nxt;
      out_ver_r    <= ver_nxt;
      out_dlen_r   <= dlen_nxt;
      out_slen_r   <= slen_nxt;
      out_tlen_r   <= tlen_nxt;
      out_plen_r   <= plen_nxt;
      out_pn_r     <= pn_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_form_bit       = out_flag_r[7];
  assign out_fixed_flag     = out_flag_r[6];
  assign out_long_type      = out_flag_r[5:4];
  assign out_reserved_field = out_flag_r[3:2];
  assign out_pn_length      = {1'b0, out_flag_r[1:0]} + 3'd1;
  assign out_version_word   = out_ver_r;
  assign out_dest_id_length = out_dlen_r;
  assign out_src_id_length  = out_slen_r;
  assign out_token_size     = out_tlen_r;
  assign out_payload_size   = out_plen_r;
  assign out_packet_num     = out_pn_r;

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("input stalled with no pending result");

  // mid-packet the byte counter has counted the flag byte
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FIRST) |-> (cnt_r != 3'd0))
    else $error("byte counter zero inside a packet");

  // short-header status only for a flag byte with bit 7 clear
  a_short_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_SHORT) |-> !out_flag_r[7])
    else $error("short-header status with long form bit");

  // any other status belongs to a long-header packet
  a_long_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_SHORT) |-> out_flag_r[7])
    else $error("long-header status with short form bit");

endmodule
